>>> hw/rtl/vrma_pkg.sv
// shared types, codes and helpers of the virtual region map allocator
package vrma_pkg;

    localparam int REQ_W      = 2;
    localparam int PROT_W     = 3;
    localparam int STATUS_W   = 3;
    localparam int SLOT_OUT_W = 4;
    localparam int PTE_W      = 8;
    localparam int CFG_IDX_W  = 1;

    localparam logic [REQ_W-1:0] REQ_MAP   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FAULT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_SLOT   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ZERO_LEN  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_REGION = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NO_ACCESS = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_BASE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_LIMIT = 1'd1;

    localparam logic [PTE_W-1:0] PTE_BASE = 8'hD1;

    typedef struct packed {
        logic start;
        logic en;
        logic entry_valid;
    } vrma_scan_ctl_t;

    function automatic logic [PTE_W-1:0] pte_bits(input logic [PROT_W-1:0] p);
        logic [PTE_W-1:0] r;
        r = PTE_BASE;
        if (p[0]) r = r | 8'h02;
        if (p[1]) r = r | 8'h04;
        if (p[2]) r = r | 8'h08;
        return r;
    endfunction

endpackage

>>> hw/rtl/virtual_region_map_allocator_core.sv
// virtual region map allocator top level: control, config registers, result register
//
// channel  dir  handshake          word
// s_       in   s_valid/s_ready    req_type, addr, length, prot
// m_       out  m_valid/m_ready    status, region_start, slot, pte_perm
// cfg_     in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// one table pass reads every entry from the region ram
// fault: one pass; map: one pass per candidate, up to NUM_REGIONS+2 passes
// clear, zero length and unknown types: no table pass
// synchronous active-low reset clears valid bits and control; ram is not cleared
// one word in flight; the next is taken while a result waits in the output register
module virtual_region_map_allocator_core #(
    parameter int NUM_REGIONS = 16,
    parameter int PAGE_BITS   = 12,
    parameter int ADDR_BITS   = 39
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [vrma_pkg::REQ_W-1:0]          s_req_type,
    input  logic [ADDR_BITS-1:0]                s_addr,
    input  logic [ADDR_BITS-1:0]                s_length,
    input  logic [vrma_pkg::PROT_W-1:0]         s_prot,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [vrma_pkg::STATUS_W-1:0]       m_status,
    output logic [ADDR_BITS-1:0]                m_region_start,
    output logic [vrma_pkg::SLOT_OUT_W-1:0]     m_slot,
    output logic [vrma_pkg::PTE_W-1:0]          m_pte_perm,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [vrma_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ADDR_BITS-1:0]                cfg_data
);
    localparam int PN_W   = ADDR_BITS - PAGE_BITS;
    localparam int CNT_W  = PN_W + 1;
    localparam int E_W    = PN_W + 3;
    localparam int SLOT_W = $clog2(NUM_REGIONS);
    localparam int IT_W   = $clog2(NUM_REGIONS + 1);
    localparam int MEM_W  = PN_W + CNT_W + vrma_pkg::PROT_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [ADDR_BITS-1:0] search_base_reg, search_limit_reg;
    logic [vrma_pkg::REQ_W-1:0]  req_reg;
    logic [vrma_pkg::PROT_W-1:0] prot_reg;
    logic [CNT_W-1:0]  n_reg;
    logic [E_W-1:0]    cand_reg;
    logic              exact_reg;
    logic [IT_W-1:0]   iter_reg;
    logic [SLOT_W-1:0] rd_idx_reg, eval_idx_reg;
    logic              eval_vld_reg;
    logic [NUM_REGIONS-1:0] valid_reg;

    logic [vrma_pkg::STATUS_W-1:0]   res_status_reg;
    logic [ADDR_BITS-1:0]            res_start_reg;
    logic [vrma_pkg::SLOT_OUT_W-1:0] res_slot_reg;
    logic [vrma_pkg::PTE_W-1:0]      res_perm_reg;

    logic                            m_valid_reg;
    logic [vrma_pkg::STATUS_W-1:0]   m_status_reg;
    logic [ADDR_BITS-1:0]            m_start_reg;
    logic [vrma_pkg::SLOT_OUT_W-1:0] m_slot_reg;
    logic [vrma_pkg::PTE_W-1:0]      m_perm_reg;

    logic s_acc, out_free;
    logic [CNT_W-1:0] n_in;
    logic [ADDR_BITS:0] len_sum;
    logic exact_in;

    logic [MEM_W-1:0] rdata, wdata;
    logic             we;
    logic [SLOT_W-1:0] free_idx;
    logic              free_any;

    vrma_pkg::vrma_scan_ctl_t scan_ctl;
    logic [E_W-1:0]    best_end;
    logic              hit;
    logic [SLOT_W-1:0] hit_idx;
    logic [PN_W-1:0]   hit_page;
    logic [vrma_pkg::PROT_W-1:0] hit_prot;

    logic [E_W-1:0] best_sum;
    logic           over_limit, last_iter, is_map;

    assign s_ready   = (state_reg == S_IDLE);
    assign s_acc     = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;

    assign len_sum  = {1'b0, s_length} + (ADDR_BITS+1)'({PAGE_BITS{1'b1}});
    assign n_in     = len_sum[ADDR_BITS:PAGE_BITS];
    assign exact_in = (s_addr != '0) && (s_addr[PAGE_BITS-1:0] == '0);

    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = NUM_REGIONS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_any = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    assign best_sum   = best_end + E_W'(n_reg);
    assign over_limit = best_sum > E_W'(search_limit_reg[ADDR_BITS-1:PAGE_BITS]);
    assign last_iter  = (iter_reg == IT_W'(NUM_REGIONS));
    assign is_map     = (req_reg == vrma_pkg::REQ_MAP);

    assign we    = (state_reg == S_CHECK) && is_map && (best_end == '0) && free_any;
    assign wdata = {cand_reg[PN_W-1:0], n_reg, prot_reg};

    assign scan_ctl.start       = (state_reg == S_SCAN) && (rd_idx_reg == '0);
    assign scan_ctl.en          = eval_vld_reg;
    assign scan_ctl.entry_valid = valid_reg[eval_idx_reg];

    vrma_ram #(.WIDTH(MEM_W), .DEPTH(NUM_REGIONS)) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (free_idx),
        .wdata (wdata),
        .raddr (rd_idx_reg),
        .rdata (rdata)
    );

    vrma_scan #(.PN_W(PN_W), .CNT_W(CNT_W), .SLOT_W(SLOT_W)) u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (scan_ctl),
        .idx         (eval_idx_reg),
        .entry_page  (rdata[MEM_W-1 -: PN_W]),
        .entry_pages (rdata[vrma_pkg::PROT_W +: CNT_W]),
        .entry_prot  (rdata[vrma_pkg::PROT_W-1:0]),
        .cand        (cand_reg),
        .npages      (n_reg),
        .best_end    (best_end),
        .hit         (hit),
        .hit_idx     (hit_idx),
        .hit_page    (hit_page),
        .hit_prot    (hit_prot)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    if ((s_req_type == vrma_pkg::REQ_MAP && n_in != '0) ||
                        s_req_type == vrma_pkg::REQ_FAULT) begin
                        state_next = S_SCAN;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (rd_idx_reg == SLOT_W'(NUM_REGIONS - 1)) state_next = S_DRAIN;
            end
            S_DRAIN: state_next = S_CHECK;
            S_CHECK: begin
                if (is_map && best_end != '0 && (exact_reg || (!last_iter && !over_limit))) begin
                    state_next = S_SCAN;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            search_base_reg  <= '0;
            search_limit_reg <= '1;
            valid_reg        <= '0;
            m_valid_reg      <= 1'b0;
            eval_vld_reg     <= 1'b0;
            rd_idx_reg       <= '0;
        end else begin
            state_reg    <= state_next;
            eval_vld_reg <= (state_reg == S_SCAN);
            eval_idx_reg <= rd_idx_reg;

            if (cfg_valid && cfg_ready) begin
                if (cfg_index == vrma_pkg::CFG_SEARCH_BASE) search_base_reg <= cfg_data;
                if (cfg_index == vrma_pkg::CFG_SEARCH_LIMIT) search_limit_reg <= cfg_data;
            end

            if (state_reg == S_SCAN) begin
                rd_idx_reg <= (rd_idx_reg == SLOT_W'(NUM_REGIONS - 1)) ? '0 :
                              rd_idx_reg + SLOT_W'(1);
            end

            if (state_reg == S_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_acc) begin
                        req_reg        <= s_req_type;
                        prot_reg       <= s_prot;
                        n_reg          <= n_in;
                        iter_reg       <= '0;
                        exact_reg      <= exact_in;
                        res_status_reg <= (s_req_type == vrma_pkg::REQ_MAP && n_in == '0) ?
                                          vrma_pkg::ST_ZERO_LEN : vrma_pkg::ST_OK;
                        res_start_reg  <= '0;
                        res_slot_reg   <= '0;
                        res_perm_reg   <= '0;
                        rd_idx_reg     <= '0;
                        if (s_req_type == vrma_pkg::REQ_FAULT || exact_in) begin
                            cand_reg <= E_W'(s_addr[ADDR_BITS-1:PAGE_BITS]);
                        end else begin
                            cand_reg <= E_W'(search_base_reg[ADDR_BITS-1:PAGE_BITS]);
                        end
                        if (s_req_type == vrma_pkg::REQ_CLEAR) valid_reg <= '0;
                    end
                end
                S_CHECK: begin
                    if (is_map) begin
                        if (best_end == '0) begin
                            if (!free_any) begin
                                res_status_reg <= vrma_pkg::ST_NO_SLOT;
                            end else begin
                                valid_reg[free_idx] <= 1'b1;
                                res_start_reg <= {cand_reg[PN_W-1:0], {PAGE_BITS{1'b0}}};
                                res_slot_reg  <= vrma_pkg::SLOT_OUT_W'(free_idx);
                            end
                        end else if (exact_reg) begin
                            exact_reg <= 1'b0;
                            iter_reg  <= '0;
                            cand_reg  <= E_W'(search_base_reg[ADDR_BITS-1:PAGE_BITS]);
                        end else if (last_iter || over_limit) begin
                            res_status_reg <= vrma_pkg::ST_NO_SPACE;
                        end else begin
                            cand_reg <= best_end;
                            iter_reg <= iter_reg + IT_W'(1);
                        end
                    end else if (hit) begin
                        res_start_reg <= {hit_page, {PAGE_BITS{1'b0}}};
                        res_slot_reg  <= vrma_pkg::SLOT_OUT_W'(hit_idx);
                        if (hit_prot == '0) begin
                            res_status_reg <= vrma_pkg::ST_NO_ACCESS;
                        end else begin
                            res_perm_reg <= vrma_pkg::pte_bits(hit_prot);
                        end
                    end else begin
                        res_status_reg <= vrma_pkg::ST_NO_REGION;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        m_status_reg <= res_status_reg;
                        m_start_reg  <= res_start_reg;
                        m_slot_reg   <= res_slot_reg;
                        m_perm_reg   <= res_perm_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_region_start = m_start_reg;
    assign m_slot         = m_slot_reg;
    assign m_pte_perm     = m_perm_reg;
endmodule

>>> hw/rtl/vrma_ram.sv
// generic single write port ram with registered read
module vrma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

>>> hw/rtl/vrma_scan.sv
// per-entry overlap and containment accumulator for one table pass
module vrma_scan #(
    parameter int PN_W   = 27,
    parameter int CNT_W  = 28,
    parameter int SLOT_W = 4
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  vrma_pkg::vrma_scan_ctl_t     ctl,
    input  logic [SLOT_W-1:0]            idx,
    input  logic [PN_W-1:0]              entry_page,
    input  logic [CNT_W-1:0]             entry_pages,
    input  logic [vrma_pkg::PROT_W-1:0]  entry_prot,
    input  logic [PN_W+2:0]              cand,
    input  logic [CNT_W-1:0]             npages,
    output logic [PN_W+2:0]              best_end,
    output logic                         hit,
    output logic [SLOT_W-1:0]            hit_idx,
    output logic [PN_W-1:0]              hit_page,
    output logic [vrma_pkg::PROT_W-1:0]  hit_prot
);
    localparam int E_W = PN_W + 3;

    logic [E_W-1:0] vs, ve, s_end;
    logic           ovl, contain;
    logic [E_W-1:0] best_reg;
    logic           hit_reg;
    logic [SLOT_W-1:0] hit_idx_reg;
    logic [PN_W-1:0]   hit_page_reg;
    logic [vrma_pkg::PROT_W-1:0] hit_prot_reg;

    assign vs      = E_W'(entry_page);
    assign ve      = vs + E_W'(entry_pages);
    assign s_end   = cand + E_W'(npages);
    assign ovl     = ctl.entry_valid && (cand < ve) && (s_end > vs);
    assign contain = ctl.entry_valid && (cand >= vs) && (cand < ve);

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.start) begin
            best_reg <= '0;
            hit_reg  <= 1'b0;
        end else if (ctl.en) begin
            if (ovl && (ve > best_reg)) begin
                best_reg <= ve;
            end
            if (contain && !hit_reg) begin
                hit_reg      <= 1'b1;
                hit_idx_reg  <= idx;
                hit_page_reg <= entry_page;
                hit_prot_reg <= entry_prot;
            end
        end
    end

    assign best_end = best_reg;
    assign hit      = hit_reg;
    assign hit_idx  = hit_idx_reg;
    assign hit_page = hit_page_reg;
    assign hit_prot = hit_prot_reg;
endmodule

>>> hw/rtl/vrma_checker.sv
// port-level checker for the allocator core and its bind
module vrma_checker #(
    parameter int ADDR_BITS = 39
) (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [vrma_pkg::STATUS_W-1:0]   m_status,
    input logic [ADDR_BITS-1:0]            m_region_start,
    input logic [vrma_pkg::SLOT_OUT_W-1:0] m_slot,
    input logic [vrma_pkg::PTE_W-1:0]      m_pte_perm
);
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_region_start))
        else $error("result word changed while stalled");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken twice in a row");

    a_perm_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_pte_perm != '0 |-> m_status == vrma_pkg::ST_OK)
        else $error("permission bits on a failed word");

    a_zero_len_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == vrma_pkg::ST_ZERO_LEN || m_status == vrma_pkg::ST_NO_SPACE ||
                    m_status == vrma_pkg::ST_NO_SLOT)
        |-> m_region_start == '0 && m_slot == '0 && m_pte_perm == '0)
        else $error("failed map word carries data");
endmodule

bind virtual_region_map_allocator_core vrma_checker #(.ADDR_BITS(ADDR_BITS)) u_vrma_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_status       (m_status),
    .m_region_start (m_region_start),
    .m_slot         (m_slot),
    .m_pte_perm     (m_pte_perm)
);

>>> verif/testbench.sv
// self-checking testbench of the virtual region map allocator core
module testbench;

    localparam int NREG = 16;
    localparam int PGB = 12;
    localparam int AW = 39;
    localparam logic [vrma_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam logic [AW-1:0] AMAX = {AW{1'b1}};
    localparam int STALL_LIMIT = 20000;

    typedef enum logic [1:0] {K_REQ, K_CFG, K_DRAIN, K_PHASE} step_kind_t;

    typedef struct {
        step_kind_t kind;
        logic [vrma_pkg::REQ_W-1:0] req;
        logic [AW-1:0] addr;
        logic [AW-1:0] len;
        logic [vrma_pkg::PROT_W-1:0] prot;
        logic [vrma_pkg::CFG_IDX_W-1:0] idx;
        int idle_pct;
        int stall_pct;
    } step_t;

    typedef struct packed {
        logic [vrma_pkg::STATUS_W-1:0] status;
        logic [AW-1:0] start;
        logic [vrma_pkg::SLOT_OUT_W-1:0] slot;
        logic [vrma_pkg::PTE_W-1:0] perm;
    } region_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0, m_ready = 1'b0, cfg_valid = 1'b0;
    logic s_ready, m_valid, cfg_ready;
    logic [vrma_pkg::REQ_W-1:0] s_req_type = '0;
    logic [AW-1:0] s_addr = '0, s_length = '0, cfg_data = '0;
    logic [vrma_pkg::PROT_W-1:0] s_prot = '0;
    logic [vrma_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [vrma_pkg::STATUS_W-1:0] m_status;
    logic [AW-1:0] m_region_start;
    logic [vrma_pkg::SLOT_OUT_W-1:0] m_slot;
    logic [vrma_pkg::PTE_W-1:0] m_pte_perm;

    virtual_region_map_allocator_core #(
        .NUM_REGIONS(NREG), .PAGE_BITS(PGB), .ADDR_BITS(AW)
    ) i_dut (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // shadow region table
    logic [AW-PGB-1:0] tbl_page [NREG];
    logic [AW-PGB:0] tbl_pages [NREG];
    logic [vrma_pkg::PROT_W-1:0] tbl_prot [NREG];
    logic tbl_valid [NREG];
    logic [AW-1:0] base_reg = '0;
    logic [AW-1:0] limit_reg = AMAX;
    logic [AW-1:0] base_hint = '0;

    step_t plan_q[$];
    region_result_t pending_results[$];
    int errors = 0, stall_cycles = 0, words_in = 0, words_out = 0;
    int idle_pct = 0, stall_pct = 0, drain_cnt = 0;
    int status_seen [8];

    function automatic logic [63:0] overlap_end(logic [63:0] s, logic [63:0] n);
        logic [63:0] best, vs, ve;
        best = 0;
        for (int i = 0; i < NREG; i++) begin
            vs = 64'(tbl_page[i]);
            ve = vs + 64'(tbl_pages[i]);
            if (tbl_valid[i] && s < ve && s + n > vs && ve > best) best = ve;
        end
        return best;
    endfunction

    function automatic region_result_t region_table_step(step_t t);
        region_result_t r;
        logic [63:0] n, c, e, pa, vs, ve;
        logic found;
        int slot;
        r = '0;
        slot = -1;
        found = 1'b0;
        case (t.req)
            vrma_pkg::REQ_MAP: begin
                n = (64'(t.len) + 64'hFFF) >> PGB;
                if (n == 0) begin
                    r.status = vrma_pkg::ST_ZERO_LEN;
                    return r;
                end
                if (t.addr != 0 && t.addr[PGB-1:0] == 0 &&
                    overlap_end(64'(t.addr) >> PGB, n) == 0) begin
                    c = 64'(t.addr) >> PGB;
                end else begin
                    c = 64'(base_reg) >> PGB;
                    for (int k = 0; k <= NREG; k++) begin
                        e = overlap_end(c, n);
                        if (e == 0) begin
                            found = 1'b1;
                            break;
                        end
                        c = e;
                        if (((c + n) << PGB) > 64'(limit_reg)) break;
                    end
                    if (!found) begin
                        r.status = vrma_pkg::ST_NO_SPACE;
                        return r;
                    end
                end
                for (int i = NREG - 1; i >= 0; i--) if (!tbl_valid[i]) slot = i;
                if (slot < 0) begin
                    r.status = vrma_pkg::ST_NO_SLOT;
                    return r;
                end
                tbl_page[slot] = c[AW-PGB-1:0];
                tbl_pages[slot] = n[AW-PGB:0];
                tbl_prot[slot] = t.prot;
                tbl_valid[slot] = 1'b1;
                r.start = {c[AW-PGB-1:0], {PGB{1'b0}}};
                r.slot = slot[vrma_pkg::SLOT_OUT_W-1:0];
            end
            vrma_pkg::REQ_FAULT: begin
                pa = 64'(t.addr) >> PGB;
                r.status = vrma_pkg::ST_NO_REGION;
                for (int i = 0; i < NREG; i++) begin
                    vs = 64'(tbl_page[i]);
                    ve = vs + 64'(tbl_pages[i]);
                    if (tbl_valid[i] && pa >= vs && pa < ve) begin
                        r.start = {tbl_page[i], {PGB{1'b0}}};
                        r.slot = i[vrma_pkg::SLOT_OUT_W-1:0];
                        r.status = (tbl_prot[i] == 0) ? vrma_pkg::ST_NO_ACCESS :
                                   vrma_pkg::ST_OK;
                        if (tbl_prot[i] != 0)
                            r.perm = vrma_pkg::PTE_BASE | {4'b0, tbl_prot[i], 1'b0};
                        return r;
                    end
                end
            end
            vrma_pkg::REQ_CLEAR: begin
                for (int i = 0; i < NREG; i++) tbl_valid[i] = 1'b0;
            end
            default: ;
        endcase
        return r;
    endfunction

    // sender side and register port
    always @(posedge aclk) begin
        logic nv_s, nv_c;
        step_t h;
        nv_s = s_valid && !s_ready;
        nv_c = cfg_valid && !cfg_ready;
        if (!aresetn) begin
            nv_s = 1'b0;
            nv_c = 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                h.req = s_req_type; h.addr = s_addr; h.len = s_length; h.prot = s_prot;
                pending_results.push_back(region_table_step(h));
                words_in++;
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == vrma_pkg::CFG_SEARCH_BASE) base_reg = cfg_data;
                else limit_reg = cfg_data;
            end
            if (!nv_s && !nv_c && plan_q.size() > 0) begin
                h = plan_q[0];
                case (h.kind)
                    K_PHASE: begin
                        idle_pct = h.idle_pct;
                        stall_pct = h.stall_pct;
                        void'(plan_q.pop_front());
                    end
                    K_DRAIN: begin
                        if (pending_results.size() == 0 && !s_valid) drain_cnt++;
                        if (drain_cnt >= 6) begin
                            drain_cnt = 0;
                            void'(plan_q.pop_front());
                        end
                    end
                    K_CFG: begin
                        nv_c = 1'b1;
                        cfg_index <= h.idx;
                        cfg_data <= h.addr;
                        void'(plan_q.pop_front());
                    end
                    default: begin
                        if ($urandom_range(0, 99) >= idle_pct) begin
                            nv_s = 1'b1;
                            s_req_type <= h.req;
                            s_addr <= h.addr;
                            s_length <= h.len;
                            s_prot <= h.prot;
                            void'(plan_q.pop_front());
                        end
                    end
                endcase
            end
        end
        s_valid <= nv_s;
        cfg_valid <= nv_c;
    end

    // result side
    always @(posedge aclk) begin
        region_result_t want;
        m_ready <= aresetn && ($urandom_range(0, 99) >= stall_pct);
        if (aresetn && m_valid && m_ready) begin
            words_out++;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected word status=%0d start=%h slot=%0d perm=%h",
                         $time, m_status, m_region_start, m_slot, m_pte_perm);
            end else begin
                want = pending_results.pop_front();
                status_seen[want.status]++;
                if (m_status !== want.status) begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d", $time, want.status, m_status);
                end
                if (m_region_start !== want.start) begin
                    errors++;
                    $display("%0t: region_start expected %h actual %h", $time, want.start,
                             m_region_start);
                end
                if (m_slot !== want.slot) begin
                    errors++;
                    $display("%0t: slot expected %0d actual %0d", $time, want.slot, m_slot);
                end
                if (m_pte_perm !== want.perm) begin
                    errors++;
                    $display("%0t: pte_perm expected %h actual %h", $time, want.perm,
                             m_pte_perm);
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else
            stall_cycles <= stall_cycles + 1;
    end

    function automatic logic [AW-1:0] rnd_full();
        return AW'({$urandom, $urandom});
    endfunction

    function automatic void add_req(logic [vrma_pkg::REQ_W-1:0] req, logic [AW-1:0] addr,
                                    logic [AW-1:0] len, logic [vrma_pkg::PROT_W-1:0] prot);
        step_t t;
        t = '{K_REQ, req, addr, len, prot, '0, 0, 0};
        plan_q.push_back(t);
    endfunction

    function automatic void add_cfg(logic [vrma_pkg::CFG_IDX_W-1:0] idx, logic [AW-1:0] data);
        step_t t;
        t = '{K_DRAIN, '0, '0, '0, '0, '0, 0, 0};
        plan_q.push_back(t);
        t = '{K_CFG, '0, data, '0, '0, idx, 0, 0};
        plan_q.push_back(t);
    endfunction

    function automatic void add_phase(int idle, int stall);
        step_t t;
        t = '{K_PHASE, '0, '0, '0, '0, '0, idle, stall};
        plan_q.push_back(t);
    endfunction

    function automatic logic [AW-1:0] near_addr();
        return AW'($urandom_range(0, 32'h3FFFF)) + ($urandom_range(0, 3) == 0 ? AW'(0) :
               (AW'($urandom_range(0, 40)) << PGB));
    endfunction

    function automatic void add_random_req();
        int pick;
        logic [AW-1:0] a, l;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            case ($urandom_range(0, 3))
                0: a = '0;
                1: a = AW'($urandom_range(0, 48)) << PGB;
                2: a = base_hint + (AW'($urandom_range(0, 64)) << PGB);
                default: a = near_addr();
            endcase
            l = ($urandom_range(0, 19) == 0) ? rnd_full() :
                AW'($urandom_range(0, 6 * 4096));
            add_req(vrma_pkg::REQ_MAP, a, l, 3'($urandom_range(0, 7)));
        end else if (pick < 88) begin
            a = ($urandom_range(0, 9) == 0) ? rnd_full() : near_addr();
            add_req(vrma_pkg::REQ_FAULT, a, rnd_full(), 3'($urandom_range(0, 7)));
        end else if (pick < 94) begin
            add_req(vrma_pkg::REQ_CLEAR, rnd_full(), rnd_full(), 3'($urandom_range(0, 7)));
        end else if (pick < 97) begin
            add_req(REQ_UNUSED, rnd_full(), rnd_full(), 3'($urandom_range(0, 7)));
        end else begin
            add_req(vrma_pkg::REQ_MAP, rnd_full(), rnd_full(), 3'($urandom_range(0, 7)));
        end
    endfunction

    initial begin
        logic [AW-1:0] b;
        for (int i = 0; i < NREG; i++) tbl_valid[i] = 1'b0;
        foreach (status_seen[i]) status_seen[i] = 0;

        // directed part, default registers
        add_phase(0, 0);
        add_req(vrma_pkg::REQ_MAP, 39'h1000, '0, 3'd7);
        add_req(vrma_pkg::REQ_MAP, '0, 39'd1, 3'd1);
        add_req(vrma_pkg::REQ_MAP, 39'h5000, 39'h2000, 3'd0);
        add_req(vrma_pkg::REQ_MAP, 39'h5123, 39'h1000, 3'd2);
        add_req(vrma_pkg::REQ_MAP, 39'h5000, 39'h1000, 3'd4);
        add_req(vrma_pkg::REQ_FAULT, 39'h5FFF, '0, '0);
        add_req(vrma_pkg::REQ_FAULT, 39'h0000, '0, '0);
        add_req(vrma_pkg::REQ_FAULT, 39'h1ABC, '0, '0);
        add_req(vrma_pkg::REQ_FAULT, 39'h7000, '0, '0);
        add_req(vrma_pkg::REQ_MAP, AMAX & ~39'hFFF, AMAX, 3'd3);
        add_req(vrma_pkg::REQ_FAULT, AMAX, AMAX, 3'd7);
        add_req(vrma_pkg::REQ_MAP, '0, AMAX, 3'd5);
        for (int i = 0; i < 5; i++) add_req(vrma_pkg::REQ_MAP, '0, 39'h3000, 3'(i));
        add_req(REQ_UNUSED, AMAX, AMAX, 3'd7);
        add_req(vrma_pkg::REQ_CLEAR, '0, '0, '0);
        add_req(vrma_pkg::REQ_FAULT, 39'h1000, '0, '0);

        // table full and out-of-room search
        add_cfg(vrma_pkg::CFG_SEARCH_BASE, 39'h10FFF);
        add_cfg(vrma_pkg::CFG_SEARCH_LIMIT, 39'h14000);
        add_req(vrma_pkg::REQ_MAP, '0, 39'h2000, 3'd1);
        add_req(vrma_pkg::REQ_MAP, '0, 39'h2000, 3'd1);
        add_req(vrma_pkg::REQ_MAP, '0, 39'h2000, 3'd1);
        for (int i = 0; i < 15; i++)
            add_req(vrma_pkg::REQ_MAP, 39'(i + 64) << PGB, 39'd10, 3'd6);
        add_req(vrma_pkg::REQ_MAP, '0, '0, '0);
        add_req(vrma_pkg::REQ_CLEAR, '0, '0, '0);

        // random phases at several register settings
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    b = '0;
                    add_cfg(vrma_pkg::CFG_SEARCH_LIMIT, AMAX);
                    add_phase(0, 0);
                end
                1: begin
                    b = AMAX;
                    add_cfg(vrma_pkg::CFG_SEARCH_LIMIT, '0);
                    add_phase(82, 0);
                end
                2: begin
                    b = AW'($urandom_range(0, 256)) << PGB;
                    add_cfg(vrma_pkg::CFG_SEARCH_LIMIT,
                            b + (AW'($urandom_range(4, 40)) << PGB));
                    add_phase(0, 82);
                end
                3: begin
                    b = rnd_full();
                    add_cfg(vrma_pkg::CFG_SEARCH_LIMIT, rnd_full());
                    add_phase(19, 19);
                end
                default: begin
                    b = 39'h20000;
                    add_cfg(vrma_pkg::CFG_SEARCH_LIMIT, AMAX);
                    add_phase(0, 0);
                end
            endcase
            add_cfg(vrma_pkg::CFG_SEARCH_BASE, b);
            base_hint = b & ~AW'(12'hFFF);
            add_req(vrma_pkg::REQ_CLEAR, '0, '0, '0);
            for (int i = 0; i < 66; i++) add_random_req();
            add_phase(0, 0);
            for (int i = 0; i < 6; i++) add_random_req();
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (plan_q.size() != 0 || s_valid || cfg_valid || pending_results.size() != 0)
            @(posedge aclk);
        repeat (400) @(posedge aclk);
        $display("%0d request words sent, %0d result words checked", words_in, words_out);
        $display("status mix ok=%0d no_space=%0d no_slot=%0d zero_len=%0d",
                 status_seen[vrma_pkg::ST_OK], status_seen[vrma_pkg::ST_NO_SPACE],
                 status_seen[vrma_pkg::ST_NO_SLOT], status_seen[vrma_pkg::ST_ZERO_LEN]);
        $display("status mix no_region=%0d no_access=%0d",
                 status_seen[vrma_pkg::ST_NO_REGION], status_seen[vrma_pkg::ST_NO_ACCESS]);
        if (errors == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
